### rtl/core/smenc_pkg.sv
`timescale 1ns / 1ps

package smenc_pkg;

	// decoded unit counts of valid codes fit in this many bits
	localparam int UNIT_W = 20;
	// largest granule log2 value; larger writes saturate here
	localparam logic [4:0] ALIGN_MAX = 5'd16;
	// decoded value of the largest valid code
	localparam logic [UNIT_W-1:0] UNIT_MAX = 20'd950272;
	localparam logic [7:0] CODE_INVALID = 8'hff;
	localparam logic [7:0] CODE_ZERO = 8'h00;
	// largest rounded size is UNIT_W bits shifted up by ALIGN_MAX
	localparam int ROUND_W = UNIT_W + 16;

	typedef struct packed {
		logic [7:0]        code;
		logic [UNIT_W-1:0] units;
		logic              over;
	} enc_result_t;

	// mantissa offset of exponent band e
	function automatic logic [4:0] band_base(input logic [3:0] e);
		return 5'd16 - (5'd15 >> e);
	endfunction

	// largest unit count that band e can still represent
	function automatic logic [UNIT_W-1:0] band_limit(input logic [3:0] e);
		logic [UNIT_W-1:0] top;
		top = (e == 4'd15) ? UNIT_W'(29) : (UNIT_W'(15) + UNIT_W'(band_base(e)));
		return top << e;
	endfunction

endpackage

### rtl/core/size_minifloat_encoder_core.sv
`timescale 1ns / 1ps

// Size minifloat encoder. Every byte_size beat taken with start is rounded up to the
// configured granule and turned into the smallest 8-bit size code that covers it, plus
// that code's size in bytes. busy never rises, so a beat can be taken every cycle; each
// result shows on the outputs for one cycle with done, after passing through an input
// register, a register after the granule round-up, and the result register. The
// receiver cannot stall, so it must take results as they come. Sizes beyond 950272
// granules give code 0xff, rounded_size 0 and out_of_range. Write the granule log2
// with cfg_we only while no beat is in flight; values above 16 read as 16.
module size_minifloat_encoder_core #(
	parameter int SIZE_WIDTH = 36
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [SIZE_WIDTH-1:0] byte_size,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	output logic                  done,
	output logic [7:0]            size_code,
	output logic [SIZE_WIDTH-1:0] rounded_size,
	output logic                  out_of_range
);

	localparam int WIDE_W = (SIZE_WIDTH > smenc_pkg::ROUND_W) ? SIZE_WIDTH
		: smenc_pkg::ROUND_W;

	logic [4:0]            align_q;
	logic                  valid_s1;
	logic [SIZE_WIDTH-1:0] byte_size_s1;
	logic                  valid_s2;
	logic [SIZE_WIDTH-1:0] units_s2;
	logic [SIZE_WIDTH-1:0] units_c;
	smenc_pkg::enc_result_t enc_c;
	logic [WIDE_W-1:0]     bytes_wide;
	logic                  done_q;
	logic [7:0]            size_code_q;
	logic [SIZE_WIDTH-1:0] rounded_size_q;
	logic                  out_of_range_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= '0;
		end else if (cfg_we) begin
			align_q <= (cfg_wdata > smenc_pkg::ALIGN_MAX) ? smenc_pkg::ALIGN_MAX : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			byte_size_s1 <= byte_size;
		if (valid_s1)
			units_s2 <= units_c;
		if (valid_s2) begin
			size_code_q    <= enc_c.code;
			rounded_size_q <= bytes_wide[SIZE_WIDTH-1:0];
			out_of_range_q <= enc_c.over;
		end
	end

	smenc_align #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_align (
		.byte_size (byte_size_s1),
		.gran_log2 (align_q),
		.units     (units_c)
	);

	smenc_encode #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_encode (
		.units (units_s2),
		.result(enc_c)
	);

	// scale decoded units back to bytes
	assign bytes_wide = WIDE_W'(enc_c.units) << align_q;

	assign done         = done_q;
	assign size_code    = size_code_q;
	assign rounded_size = rounded_size_q;
	assign out_of_range = out_of_range_q;

	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("start beat did not produce a result three cycles later");

	a_range_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> size_code == smenc_pkg::CODE_INVALID && rounded_size == '0)
		else $error("out of range result carries a code or size");

	a_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> size_code != smenc_pkg::CODE_INVALID)
		else $error("in range result carries the invalid code");

	a_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && size_code == smenc_pkg::CODE_ZERO |-> rounded_size == '0)
		else $error("zero code with nonzero rounded size");

	a_align_sat: assert property (@(posedge clk) disable iff (!arst_n)
		align_q <= smenc_pkg::ALIGN_MAX)
		else $error("granule register above its maximum");

endmodule

### rtl/core/smenc_align.sv
`timescale 1ns / 1ps

module smenc_align #(
	parameter int SIZE_WIDTH = 36
) (
	input  logic [SIZE_WIDTH-1:0] byte_size,
	input  logic [4:0]            gran_log2,
	output logic [SIZE_WIDTH-1:0] units
);

	logic [SIZE_WIDTH-1:0] low_mask;
	logic                  has_rem;

	// ceiling divide by the granule; no carry out since a zero shift leaves no remainder
	always_comb begin
		low_mask = ~({SIZE_WIDTH{1'b1}} << gran_log2);
		has_rem  = |(byte_size & low_mask);
		units    = (byte_size >> gran_log2) + SIZE_WIDTH'(has_rem);
	end

endmodule

### rtl/core/smenc_encode.sv
`timescale 1ns / 1ps

module smenc_encode #(
	parameter int SIZE_WIDTH = 36
) (
	input  logic [SIZE_WIDTH-1:0] units,
	output smenc_pkg::enc_result_t result
);

	localparam int UW = smenc_pkg::UNIT_W;

	logic [UW-1:0] u;
	logic          over;
	logic [3:0]    sel_e;
	logic [UW-1:0] step;
	logic          has_rem;
	logic [4:0]    base;
	logic [UW-1:0] diff;
	logic [3:0]    mant;

	always_comb begin
		over = units > SIZE_WIDTH'(smenc_pkg::UNIT_MAX);
		u    = units[UW-1:0];

		// smallest band whose range still covers the count
		sel_e = 4'd15;
		for (int i = 15; i >= 0; i--) begin
			if (u <= smenc_pkg::band_limit(4'(i)))
				sel_e = 4'(i);
		end

		has_rem = |(u & ~({UW{1'b1}} << sel_e));
		step    = (u >> sel_e) + UW'(has_rem);
		base    = smenc_pkg::band_base(sel_e);
		diff    = step - UW'(base);
		mant    = (step > UW'(base)) ? diff[3:0] : 4'd0;

		if (over) begin
			result.code  = smenc_pkg::CODE_INVALID;
			result.units = '0;
			result.over  = 1'b1;
		end else if (u == '0) begin
			result.code  = smenc_pkg::CODE_ZERO;
			result.units = '0;
			result.over  = 1'b0;
		end else begin
			result.code  = {sel_e, mant} + 8'd1;
			result.units = (UW'(mant) + UW'(base)) << sel_e;
			result.over  = 1'b0;
		end
	end

endmodule

### test/size_minifloat_encoder_core_tb.sv
`timescale 1ns / 1ps

module size_minifloat_encoder_core_tb;

	localparam int SIZE_W = 36;
	localparam int LATENCY = 3;
	localparam int WATCHDOG = 1000;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		logic [SIZE_W-1:0] byte_size;
		logic [7:0]        code;
		logic [SIZE_W-1:0] rounded;
		logic              over;
	} size_enc_t;

	class size_code_scoreboard;
		size_enc_t pending_codes[$];
		int unsigned granule;
		int unsigned errors;

		function new();
			granule = 0;
			errors = 0;
		endfunction

		function void set_granule(input logic [4:0] v);
			granule = int'((v > smenc_pkg::ALIGN_MAX) ? smenc_pkg::ALIGN_MAX : v);
		endfunction

		function logic [63:0] band_offset(input int unsigned e);
			return 64'd16 - (64'd15 >> e);
		endfunction

		function logic [63:0] decode_units(input logic [7:0] c);
			int unsigned e;
			logic [63:0] m;
			if (c < 8'd15) return 64'(c);
			e = (c - 1) >> 4;
			m = 64'((c - 1) & 8'h0f);
			return (m + band_offset(e)) << e;
		endfunction

		function size_enc_t predict_code(input logic [SIZE_W-1:0] size);
			size_enc_t r;
			logic [63:0] units, low, lim, steps, offs;
			logic [63:0] m;
			bit hit;
			r.byte_size = size;
			low = 64'(size) & ((64'd1 << granule) - 64'd1);
			units = (64'(size) >> granule) + ((low != 0) ? 64'd1 : 64'd0);
			hit = 0;
			r.code = smenc_pkg::CODE_INVALID;
			if (units == 0) begin
				r.code = smenc_pkg::CODE_ZERO;
				hit = 1;
			end else begin
				for (int unsigned e = 0; e < 16 && !hit; e++) begin
					lim = (((e == 15) ? 64'd13 : 64'd15) + band_offset(e)) << e;
					if (units <= lim) begin
						steps = (units >> e) +
							(((units & ((64'd1 << e) - 64'd1)) != 0) ? 64'd1 : 64'd0);
						offs = band_offset(e);
						m = (steps > offs) ? steps - offs : 64'd0;
						r.code = 8'((e << 4) + m + 1);
						hit = 1;
					end
				end
			end
			if (hit) begin
				r.rounded = SIZE_W'(decode_units(r.code) << granule);
				r.over = 1'b0;
			end else begin
				r.code = smenc_pkg::CODE_INVALID;
				r.rounded = '0;
				r.over = 1'b1;
			end
			return r;
		endfunction

		function void note_size(input logic [SIZE_W-1:0] size);
			pending_codes.push_back(predict_code(size));
		endfunction

		function int pending();
			return pending_codes.size();
		endfunction

		function void check_result(input logic [7:0] code, input logic [SIZE_W-1:0] rounded,
			input logic over);
			size_enc_t x;
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected result beat: code 0x%0h rounded 0x%0h over %0b",
					$time, code, rounded, over);
				errors++;
				return;
			end
			x = pending_codes.pop_front();
			if (code !== x.code) begin
				$display("%0t: size_code for 0x%0h: expected 0x%0h, actual 0x%0h",
					$time, x.byte_size, x.code, code);
				errors++;
			end
			if (rounded !== x.rounded) begin
				$display("%0t: rounded_size for 0x%0h: expected 0x%0h, actual 0x%0h",
					$time, x.byte_size, x.rounded, rounded);
				errors++;
			end
			if (over !== x.over) begin
				$display("%0t: out_of_range for 0x%0h: expected %0b, actual %0b",
					$time, x.byte_size, x.over, over);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [SIZE_W-1:0] byte_size;
	logic              cfg_we;
	logic [4:0]        cfg_wdata;
	logic              done;
	logic [7:0]        size_code;
	logic [SIZE_W-1:0] rounded_size;
	logic              out_of_range;

	size_code_scoreboard sb;
	int unsigned idle_cycles = 0;
	int burst_left;

	size_minifloat_encoder_core #(
		.SIZE_WIDTH(SIZE_W)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.byte_size    (byte_size),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.size_code    (size_code),
		.rounded_size (rounded_size),
		.out_of_range (out_of_range)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(size_code, rounded_size, out_of_range);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_size(input logic [SIZE_W-1:0] v);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		byte_size <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_size(v);
	endtask

	// stop sending and let every outstanding beat come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_granule(input logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_granule(v);
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		logic [63:0] v;
		int w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				// land on or next to a code boundary
				v = sb.decode_units(8'($urandom_range(0, 254))) << sb.granule;
				v = v + 64'($urandom_range(0, 2)) - 64'd1;
			end
			4, 5, 6: begin
				w = $urandom_range(0, SIZE_W);
				v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
			end
			7: v = (64'($urandom_range(0, 40)) << sb.granule) + 64'($urandom_range(0, 1));
			default: v = {$urandom, $urandom};
		endcase
		return SIZE_W'(v);
	endfunction

	logic [SIZE_W-1:0] directed_a0[] = '{
		36'd0, 36'd1, 36'd14, 36'd15, 36'd16, 36'd17, 36'd31, 36'd32, 36'd33,
		36'd1000, 36'd65535, 36'd65536, 36'd65537, 36'd950271, 36'd950272,
		36'd950273, 36'hf_ffff_ffff
	};
	logic [SIZE_W-1:0] directed_a16[] = '{
		36'd0, 36'd1, 36'd65536, 36'd65537, 36'd62277025792, 36'd62277025793,
		36'hf_ffff_ffff
	};
	logic [4:0] granules[] = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd1, 5'd3, 5'd8, 5'd12,
		5'd0, 5'd0};

	initial begin
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		byte_size = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < granules.size(); p++) begin
			if (p >= 8) write_granule(5'($urandom_range(0, 31)));
			else write_granule(granules[p]);
			if (p == 0) foreach (directed_a0[i]) send_size(directed_a0[i]);
			if (p == 1) foreach (directed_a16[i]) send_size(directed_a16[i]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_size(pick_size());
				if ($urandom_range(0, 99) == 0) begin
					// hold off until the pipe is empty
					start <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/smenc_pkg.sv
rtl/core/smenc_align.sv
rtl/core/smenc_encode.sv
rtl/core/size_minifloat_encoder_core.sv
test/size_minifloat_encoder_core_tb.sv
